// File: hw/rtl/dht_pkg.sv
// ----------------------------------------------------------------------------
// dht_pkg
// Shared sizes, codes and control structures of the double-hash table.
// ----------------------------------------------------------------------------
package dht_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int KEY_BYTES   = 8;

    localparam int KEY_IN_W  = 64;
    localparam int KEY_W     = 8 * KEY_BYTES;
    localparam int IDX_W     = $clog2(TABLE_SLOTS);
    localparam int SUM_W     = $clog2(255 * KEY_BYTES + 1);
    localparam int CNT_W     = IDX_W;
    localparam int STEP_MOD  = 7;
    localparam int STEP_W    = 3;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 6;
    localparam int OUT_W     = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;        // take key and mode, form byte sum
        logic    red_step;    // latch sum mod N and sum mod 7
        logic    probe_init;  // index <= home, latch step
        logic    rd;          // read key store at current index
        logic    advance;     // index <= index + step (mod N)
        logic    ins_write;   // store key at current index, mark valid
        logic    capture;     // latch result
        status_t res_status;
        logic    res_use_slot;
        logic    out_load;    // move result into output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic mode;
        logic slot_valid;
        logic key_match;
    } stat_t;

endpackage

// File: hw/rtl/dht_ram.sv
// ----------------------------------------------------------------------------
// dht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/dht_ctrl.sv
// ----------------------------------------------------------------------------
// dht_ctrl
// Sequencer: hash reduction, probe loop, result hand-off.
// ----------------------------------------------------------------------------
module dht_ctrl
    import dht_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    output cmd_t  cmd,
    input  stat_t st
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_HOME,
        S_READ,
        S_CHECK,
        S_DONE
    } state_t;

    localparam logic [CNT_W-1:0] PROBE_LAST = CNT_W'(TABLE_SLOTS - 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.res_status = ST_FULL;
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                cmd.red_step = 1'b1;
                state_next   = S_HOME;
            end
            S_HOME:
            begin
                cmd.probe_init = 1'b1;
                cnt_next       = '0;
                state_next     = S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!st.slot_valid)
                begin
                    cmd.capture = 1'b1;
                    if (!st.mode)
                    begin
                        cmd.ins_write    = 1'b1;
                        cmd.res_status   = ST_INSERTED;
                        cmd.res_use_slot = 1'b1;
                    end
                    else
                    begin
                        cmd.res_status = ST_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end
                else if (st.key_match)
                begin
                    cmd.capture      = 1'b1;
                    cmd.res_status   = st.mode ? ST_FOUND : ST_PRESENT;
                    cmd.res_use_slot = 1'b1;
                    state_next       = S_DONE;
                end
                else if (cnt_reg == PROBE_LAST)
                begin
                    cmd.capture    = 1'b1;
                    cmd.res_status = st.mode ? ST_NOT_FOUND : ST_FULL;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                    state_next  = S_READ;
                end
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// File: hw/rtl/dht_dp.sv
// ----------------------------------------------------------------------------
// dht_dp
// Datapath: byte sum, mod reduction, probe index, key store,
// valid bits, result and output registers.
// ----------------------------------------------------------------------------
module dht_dp
    import dht_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_mode,
    input  logic [KEY_IN_W-1:0] in_key,
    input  cmd_t                cmd,
    output stat_t               st,
    output logic [OUT_W-1:0]    out_data
);

    localparam int SLOT_EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int RED_GROUPS = (SUM_W + 2) / 3;
    localparam int PAD_W      = 3 * RED_GROUPS;
    localparam int FOLD_W     = $clog2(STEP_MOD * RED_GROUPS + 1);

    logic                   mode_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [IDX_W-1:0]       remn_reg;
    logic [STEP_W-1:0]      rem7_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [TABLE_SLOTS-1:0] valid_reg;
    status_t                res_status_reg;
    logic [SLOT_W-1:0]      res_slot_reg;
    status_t                out_status_reg;
    logic [SLOT_W-1:0]      out_slot_reg;

    logic [SUM_W-1:0]       sum_in;
    logic [IDX_W-1:0]       remn_next;
    logic [PAD_W-1:0]       sum_pad;
    logic [FOLD_W-1:0]      fold1;
    logic [STEP_W:0]        fold2;
    logic [STEP_W-1:0]      rem7_next;
    logic [IDX_W:0]         idx_sum;
    logic [IDX_W-1:0]       idx_next;
    logic [SLOT_EXT_W-1:0]  idx_ext;
    logic [KEY_W-1:0]       ram_q;

    // byte sum of the used key bytes
    always_comb
    begin
        sum_in = '0;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            sum_in = sum_in + SUM_W'(in_key[8*b +: 8]);
        end
    end

    // 8 = 1 mod 7, so adding octal digits keeps the residue; fold twice, then
    // one conditional subtract
    always_comb
    begin
        remn_next = IDX_W'(sum_reg % TABLE_SLOTS);
        sum_pad   = PAD_W'(sum_reg);
        fold1     = '0;
        for (int g = 0; g < RED_GROUPS; g++)
        begin
            fold1 = fold1 + FOLD_W'(sum_pad[3*g +: 3]);
        end
        fold2     = (STEP_W+1)'(fold1[2:0]) + (STEP_W+1)'(fold1[FOLD_W-1:3]);
        rem7_next = (fold2 >= (STEP_W+1)'(STEP_MOD))
                  ? STEP_W'(fold2 - (STEP_W+1)'(STEP_MOD))
                  : fold2[STEP_W-1:0];
    end

    // step is below the table size, so one conditional subtract wraps it
    always_comb
    begin
        idx_sum  = {1'b0, idx_reg} + (IDX_W+1)'(step_reg);
        idx_next = (idx_sum >= (IDX_W+1)'(TABLE_SLOTS))
                 ? IDX_W'(idx_sum - (IDX_W+1)'(TABLE_SLOTS))
                 : idx_sum[IDX_W-1:0];
        idx_ext  = SLOT_EXT_W'(idx_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_mode;
            key_reg  <= in_key[KEY_W-1:0];
            sum_reg  <= sum_in;
        end

        if (cmd.red_step)
        begin
            remn_reg <= remn_next;
            rem7_reg <= rem7_next;
        end

        if (cmd.probe_init)
        begin
            idx_reg  <= remn_reg;
            step_reg <= STEP_W'(STEP_MOD) - rem7_reg;
        end
        else if (cmd.advance)
        begin
            idx_reg <= idx_next;
        end

        if (cmd.capture)
        begin
            res_status_reg <= cmd.res_status;
            res_slot_reg   <= cmd.res_use_slot ? idx_ext[SLOT_W-1:0] : '0;
        end

        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.ins_write)
        begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    dht_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_key_store (
        .clk   (clk),
        .we    (cmd.ins_write),
        .waddr (idx_reg),
        .wdata (key_reg),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (ram_q)
    );

    assign st.mode       = mode_reg;
    assign st.slot_valid = valid_reg[idx_reg];
    assign st.key_match  = (ram_q == key_reg);

    assign out_data = {(OUT_W - SLOT_W - STATUS_W)'(0), out_slot_reg, out_status_reg};

endmodule

// File: hw/rtl/double_hash_table_insert_search.sv
// ----------------------------------------------------------------------------
// double_hash_table_insert_search
// Open-addressing hash table with double hashing; insert and search.
// ----------------------------------------------------------------------------
// One request is handled at a time. The key's bytes are summed on the input
// transfer, then the registered sum is reduced mod TABLE_SLOTS and mod 7, and
// a further state loads the probe index with the home slot (sum mod
// TABLE_SLOTS) and latches the step (7 - sum mod 7). Each probe has a read
// state and a compare-and-decide state because the key store is a RAM with
// registered read. A request stops at probe p (1..TABLE_SLOTS, so at most 64
// probes with 64 slots); the probe loop runs over the single RAM read port.
// The output register lets the next request be taken while a result still
// waits.
// Slot valid bits are flip-flops cleared by reset, so the table is usable
// right after reset.
// ----------------------------------------------------------------------------
module double_hash_table_insert_search
    import dht_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [KEY_IN_W-1:0] s_tdata,   // [63:0] key
    input  logic                s_tuser,   // [0] mode: 0 insert, 1 search
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata    // [2:0] status, [8:3] slot, [15:9] zero
);

    cmd_t  cmd;
    stat_t st;

    dht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .st       (st)
    );

    dht_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_mode  (s_tuser),
        .in_key   (s_tdata),
        .cmd      (cmd),
        .st       (st),
        .out_data (m_tdata)
    );

endmodule
